[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the pixel colour adjust block.
// Needs nothing else; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define LPCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Clocked check that also runs through reset.
`define LPCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define LPCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/lpca_pkg.sv]
// Types and constants for the LED pixel colour adjust block.
// Stands alone; used by led_pixel_color_adjust.
package lpca_pkg;

    localparam int NUM_CH     = 3;
    localparam int PIX_W      = 8;
    localparam int PIPE_DEPTH = 6;

    localparam int HALF_SCALE = 128;
    localparam int PCT_MAX    = 100;
    localparam int PCT_MIN    = -100;
    localparam int FULL_SCALE = 255;

    // floor(x / 100) = (x * DIV100_RCP) >> DIV100_SHIFT, exact for x < 43690
    localparam int DIV100_RCP   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_BIAS  = 50;

    // floor(y / 255) = (y * DIV255_RCP) >> DIV255_SHIFT, exact for y < 66052
    localparam int DIV255_RCP   = 65794;
    localparam int DIV255_SHIFT = 24;
    localparam int DIV255_BIAS  = 127;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef logic signed [PIX_W-1:0] t_pct;

    typedef enum logic [2:0] {
        CFG_CONTRAST   = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_GREEN_MIN  = 3'd2,
        CFG_GREEN_MAX  = 3'd3,
        CFG_RED_MIN    = 3'd4,
        CFG_RED_MAX    = 3'd5,
        CFG_BLUE_MIN   = 3'd6,
        CFG_BLUE_MAX   = 3'd7
    } t_cfg_idx;

    // Lane order follows the GRB pixel layout.
    localparam int CH_GREEN = 0;
    localparam int CH_RED   = 1;
    localparam int CH_BLUE  = 2;

endpackage

[rtl/core/led_pixel_color_adjust.sv]
// LED pixel colour adjust: contrast, brightness, clip and per-channel range map.
// Throughput: one pixel per clock.
// o_busy stays low: the six-stage pipeline has no stall; stages 1, 2, 4, 5 multiply.
// Synchronous active-low reset clears settings and all valid bits, not the payload.
// Depends on lpca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module led_pixel_color_adjust (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  lpca_pkg::t_pix      i_green_in,
    input  lpca_pkg::t_pix      i_red_in,
    input  lpca_pkg::t_pix      i_blue_in,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    output logic                o_valid,
    output lpca_pkg::t_pix      o_green_out,
    output lpca_pkg::t_pix      o_red_out,
    output lpca_pkg::t_pix      o_blue_out
);
    import lpca_pkg::*;

    // configuration
    t_pct               r_contrast;
    t_pct               r_bright;
    t_pix               r_lo [NUM_CH];
    t_pix               r_hi [NUM_CH];
    logic signed [8:0]  r_badd;
    logic signed [8:0]  n_badd;

    // pipeline
    logic [PIPE_DEPTH-2:0]  r_vld;
    logic signed [16:0]     r_s1_n [NUM_CH];
    logic signed [16:0]     n_s1_n [NUM_CH];
    logic [8:0]             r_s2_q [NUM_CH];
    logic [8:0]             n_s2_q [NUM_CH];
    logic                   r_s2_neg [NUM_CH];
    logic                   n_s2_neg [NUM_CH];
    t_pix                   r_s3_u [NUM_CH];
    t_pix                   n_s3_u [NUM_CH];
    logic signed [17:0]     r_s4_p [NUM_CH];
    logic signed [17:0]     n_s4_p [NUM_CH];
    t_pix                   r_s4_u [NUM_CH];
    t_pix                   r_s5_q [NUM_CH];
    t_pix                   n_s5_q [NUM_CH];
    logic                   r_s5_neg [NUM_CH];
    t_pix                   r_s5_u [NUM_CH];
    t_pix                   r_out [NUM_CH];
    t_pix                   n_out [NUM_CH];
    logic                   r_ovld;

    // lane temporaries
    t_pix                   pix_in [NUM_CH];
    logic signed [8:0]      s1_d [NUM_CH];
    logic signed [8:0]      s1_k;
    logic signed [17:0]     s1_prod [NUM_CH];
    logic [16:0]            s2_mag [NUM_CH];
    logic [15:0]            s2_x [NUM_CH];
    logic [28:0]            s2_prod [NUM_CH];
    logic signed [10:0]     s3_q [NUM_CH];
    logic signed [10:0]     s3_t [NUM_CH];
    logic signed [8:0]      s4_span [NUM_CH];
    logic [16:0]            s5_mag [NUM_CH];
    logic [15:0]            s5_y [NUM_CH];
    logic [32:0]            s5_prod [NUM_CH];
    logic signed [9:0]      s6_q [NUM_CH];
    logic signed [9:0]      s6_r [NUM_CH];
    logic [7:0]             b_mag;
    logic [15:0]            b_x;
    logic [28:0]            b_prod;
    logic [8:0]             b_q;
    t_pct                   cfg_pct;

    assign o_busy = 1'b0;

    assign pix_in[CH_GREEN] = i_green_in;
    assign pix_in[CH_RED]   = i_red_in;
    assign pix_in[CH_BLUE]  = i_blue_in;

    // saturate percent writes to -100..100
    always_comb begin
        cfg_pct = t_pct'(i_cfg_data);
        if (cfg_pct < t_pct'(PCT_MIN)) begin
            cfg_pct = t_pct'(PCT_MIN);
        end else if (cfg_pct > t_pct'(PCT_MAX)) begin
            cfg_pct = t_pct'(PCT_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast <= '0;
            r_bright   <= '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_lo[ch] <= '0;
                r_hi[ch] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CONTRAST:   r_contrast      <= cfg_pct;
                CFG_BRIGHTNESS: r_bright        <= cfg_pct;
                CFG_GREEN_MIN:  r_lo[CH_GREEN]  <= i_cfg_data;
                CFG_GREEN_MAX:  r_hi[CH_GREEN]  <= i_cfg_data;
                CFG_RED_MIN:    r_lo[CH_RED]    <= i_cfg_data;
                CFG_RED_MAX:    r_hi[CH_RED]    <= i_cfg_data;
                CFG_BLUE_MIN:   r_lo[CH_BLUE]   <= i_cfg_data;
                CFG_BLUE_MAX:   r_hi[CH_BLUE]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Brightness offset round(255*b/100), refreshed every cycle from the stored
    // percent; it is first used in stage 3 of the pipeline.
    always_comb begin
        b_mag  = r_bright[7] ? 8'(-r_bright) : 8'(r_bright);
        b_x    = 16'({b_mag, 8'd0}) - 16'(b_mag) + 16'(DIV100_BIAS);
        b_prod = b_x * 13'(DIV100_RCP);
        b_q    = b_prod[DIV100_SHIFT +: 9];
        n_badd = r_bright[7] ? -$signed(b_q) : $signed(b_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_badd <= '0;
        end else begin
            r_badd <= n_badd;
        end
    end

    always_comb begin
        s1_k = 9'(r_contrast) + $signed(9'(PCT_MAX));
        for (int ch = 0; ch < NUM_CH; ch++) begin
            // stage 1: (v-128)*(100+c) + 12800
            s1_d[ch]    = $signed({1'b0, pix_in[ch]}) - $signed(9'(HALF_SCALE));
            s1_prod[ch] = s1_d[ch] * s1_k;
            n_s1_n[ch]  = 17'(s1_prod[ch] + $signed(18'(HALF_SCALE * PCT_MAX)));

            // stage 2: magnitude divided by 100, rounded half away from zero
            s2_mag[ch]   = r_s1_n[ch][16] ? 17'(-r_s1_n[ch]) : 17'(r_s1_n[ch]);
            s2_x[ch]     = s2_mag[ch][15:0] + 16'(DIV100_BIAS);
            s2_prod[ch]  = s2_x[ch] * 13'(DIV100_RCP);
            n_s2_q[ch]   = s2_prod[ch][DIV100_SHIFT +: 9];
            n_s2_neg[ch] = r_s1_n[ch][16];

            // stage 3: restore sign, add brightness, clip
            s3_q[ch] = $signed({2'b00, r_s2_q[ch]});
            s3_t[ch] = (r_s2_neg[ch] ? -s3_q[ch] : s3_q[ch]) + 11'(r_badd);
            if (s3_t[ch] < 0) begin
                n_s3_u[ch] = '0;
            end else if (s3_t[ch] > $signed(11'(FULL_SCALE))) begin
                n_s3_u[ch] = t_pix'(FULL_SCALE);
            end else begin
                n_s3_u[ch] = s3_t[ch][7:0];
            end

            // stage 4: span * level
            s4_span[ch] = $signed({1'b0, r_hi[ch]}) - $signed({1'b0, r_lo[ch]});
            n_s4_p[ch]  = s4_span[ch] * $signed({1'b0, r_s3_u[ch]});

            // stage 5: magnitude divided by 255, rounded
            s5_mag[ch]  = r_s4_p[ch][17] ? 17'(-r_s4_p[ch]) : 17'(r_s4_p[ch]);
            s5_y[ch]    = s5_mag[ch][15:0] + 16'(DIV255_BIAS);
            s5_prod[ch] = s5_y[ch] * 17'(DIV255_RCP);
            n_s5_q[ch]  = s5_prod[ch][DIV255_SHIFT +: 8];

            // stage 6: offset from min, clip; zero stays zero, unset range passes
            s6_q[ch] = $signed({2'b00, r_s5_q[ch]});
            s6_r[ch] = $signed({2'b00, r_lo[ch]}) + (r_s5_neg[ch] ? -s6_q[ch] : s6_q[ch]);
            if (r_lo[ch] == '0 && r_hi[ch] == '0) begin
                n_out[ch] = r_s5_u[ch];
            end else if (r_s5_u[ch] == '0) begin
                n_out[ch] = '0;
            end else if (s6_r[ch] < 0) begin
                n_out[ch] = '0;
            end else if (s6_r[ch] > $signed(10'(FULL_SCALE))) begin
                n_out[ch] = t_pix'(FULL_SCALE);
            end else begin
                n_out[ch] = s6_r[ch][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[PIPE_DEPTH-3:0], i_start & ~o_busy};
            r_ovld <= r_vld[PIPE_DEPTH-2];
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            r_s1_n[ch]   <= n_s1_n[ch];
            r_s2_q[ch]   <= n_s2_q[ch];
            r_s2_neg[ch] <= n_s2_neg[ch];
            r_s3_u[ch]   <= n_s3_u[ch];
            r_s4_p[ch]   <= n_s4_p[ch];
            r_s4_u[ch]   <= r_s3_u[ch];
            r_s5_q[ch]   <= n_s5_q[ch];
            r_s5_neg[ch] <= r_s4_p[ch][17];
            r_s5_u[ch]   <= r_s4_u[ch];
            r_out[ch]    <= n_out[ch];
        end
    end

    assign o_valid     = r_ovld;
    assign o_green_out = r_out[CH_GREEN];
    assign o_red_out   = r_out[CH_RED];
    assign o_blue_out  = r_out[CH_BLUE];

    `LPCA_ASSERT(a_req_gives_result, i_clk, i_rst_n, i_start |-> ##PIPE_DEPTH o_valid, "request lost in pipeline")
    `LPCA_ASSERT(a_no_phantom_result, i_clk, i_rst_n, !i_start |-> ##PIPE_DEPTH !o_valid, "result without request")
    `LPCA_ASSERT(a_green_zero_kept, i_clk, i_rst_n, r_vld[PIPE_DEPTH-2] && r_s5_u[CH_GREEN] == '0 |=> o_green_out == '0, "green zero not kept")
    `LPCA_ASSERT(a_red_zero_kept, i_clk, i_rst_n, r_vld[PIPE_DEPTH-2] && r_s5_u[CH_RED] == '0 |=> o_red_out == '0, "red zero not kept")
    `LPCA_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid, "valid survives reset")

endmodule

[tb/tb_led_pixel_color_adjust.sv]
// Self-checking testbench for led_pixel_color_adjust: predicts each adjusted pixel
// and checks it against o_valid results. Depends on lpca_pkg and the block's RTL.
module tb_led_pixel_color_adjust;
    timeunit 1ns;
    timeprecision 1ps;

    import lpca_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int RAND_BLOCKS = 26;
    localparam int BLOCK_ITEMS = 50;

    typedef enum logic [1:0] {
        REQ_PIXEL,
        REQ_SETTING,
        REQ_DRAIN
    } req_kind_e;

    typedef struct {
        req_kind_e   kind;
        t_pix        green;
        t_pix        red;
        t_pix        blue;
        t_cfg_idx    idx;
        logic [7:0]  data;
        int          idle_pct;
    } request_t;

    typedef struct packed {
        t_pix green;
        t_pix red;
        t_pix blue;
    } pixel_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    t_pix        i_green_in = '0;
    t_pix        i_red_in   = '0;
    t_pix        i_blue_in  = '0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        o_busy;
    logic        o_valid;
    t_pix        o_green_out;
    t_pix        o_red_out;
    t_pix        o_blue_out;

    // Predictor's copy of the register file
    int   contrast_pct = 0;
    int   bright_pct   = 0;
    t_pix level_min [NUM_CH] = '{default: '0};
    t_pix level_max [NUM_CH] = '{default: '0};

    request_t request_q [$];
    pixel_t   adjusted_q [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;

    led_pixel_color_adjust dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_blue_in   (i_blue_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_blue_out  (o_blue_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Round n/d half away from zero, d > 0
    function automatic int round_div(int n, int d);
        int mag;
        int q;
        mag = (n < 0) ? -n : n;
        q   = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic t_pix clamp_level(int v);
        if (v < 0) return '0;
        if (v > FULL_SCALE) return t_pix'(FULL_SCALE);
        return t_pix'(v);
    endfunction

    function automatic t_pix adjust_level(t_pix v, t_pix lo, t_pix hi);
        int   offset;
        int   t;
        int   span;
        t_pix u;
        offset = round_div(FULL_SCALE * bright_pct, PCT_MAX);
        t = round_div((int'(v) - HALF_SCALE) * (PCT_MAX + contrast_pct)
                      + HALF_SCALE * PCT_MAX, PCT_MAX) + offset;
        u = clamp_level(t);
        if (lo == '0 && hi == '0) return u;
        if (u == '0) return '0;
        span = int'(hi) - int'(lo);
        return clamp_level(int'(lo) + round_div(span * int'(u), FULL_SCALE));
    endfunction

    function automatic pixel_t predict_adjusted(t_pix g, t_pix r, t_pix b);
        pixel_t p;
        p.green = adjust_level(g, level_min[CH_GREEN], level_max[CH_GREEN]);
        p.red   = adjust_level(r, level_min[CH_RED],   level_max[CH_RED]);
        p.blue  = adjust_level(b, level_min[CH_BLUE],  level_max[CH_BLUE]);
        return p;
    endfunction

    task automatic store_setting(t_cfg_idx idx, logic [7:0] data);
        int pct;
        pct = $signed(data);
        if (pct < PCT_MIN) pct = PCT_MIN;
        if (pct > PCT_MAX) pct = PCT_MAX;
        case (idx)
            CFG_CONTRAST:   contrast_pct = pct;
            CFG_BRIGHTNESS: bright_pct   = pct;
            CFG_GREEN_MIN:  level_min[CH_GREEN] = data;
            CFG_GREEN_MAX:  level_max[CH_GREEN] = data;
            CFG_RED_MIN:    level_min[CH_RED]   = data;
            CFG_RED_MAX:    level_max[CH_RED]   = data;
            CFG_BLUE_MIN:   level_min[CH_BLUE]  = data;
            CFG_BLUE_MAX:   level_max[CH_BLUE]  = data;
            default: ;
        endcase
    endtask

    // Driver: one request per cycle at most; settings and drains wait for an empty pipe
    always @(posedge i_clk) begin
        request_t   head;
        logic       accepted;
        logic       next_start;
        logic       next_we;
        accepted   = 1'b0;
        next_start = 1'b0;
        next_we    = 1'b0;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            accepted = i_start && !o_busy;
            if (accepted) begin
                adjusted_q.push_back(predict_adjusted(i_green_in, i_red_in, i_blue_in));
            end
            if (i_cfg_we) begin
                store_setting(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            end
            if (i_start && !accepted) begin
                // hold the request until taken
                next_start = 1'b1;
            end else if (request_q.size() > 0) begin
                head = request_q[0];
                case (head.kind)
                    REQ_PIXEL: begin
                        if ($urandom_range(99) >= head.idle_pct) begin
                            void'(request_q.pop_front());
                            next_start = 1'b1;
                            i_green_in <= head.green;
                            i_red_in   <= head.red;
                            i_blue_in  <= head.blue;
                        end
                    end
                    REQ_SETTING: begin
                        if (adjusted_q.size() == 0) begin
                            void'(request_q.pop_front());
                            next_we = 1'b1;
                            i_cfg_idx  <= head.idx;
                            i_cfg_data <= head.data;
                        end
                    end
                    default: begin
                        if (adjusted_q.size() == 0) begin
                            void'(request_q.pop_front());
                        end
                    end
                endcase
            end
            i_start  <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // Monitor: every strobed result must match the oldest prediction
    always @(posedge i_clk) begin
        pixel_t seen;
        pixel_t want;
        if (i_rst_n && o_valid) begin
            seen = {o_green_out, o_red_out, o_blue_out};
            if (adjusted_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result g=%0d r=%0d b=%0d at cycle %0d",
                             seen.green, seen.red, seen.blue, cycle_count);
                end
            end else begin
                want = adjusted_q.pop_front();
                if (seen.green !== want.green || seen.red !== want.red
                        || seen.blue !== want.blue) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch at cycle %0d: expected g=%0d r=%0d b=%0d, got g=%0d r=%0d b=%0d",
                                 cycle_count, want.green, want.red, want.blue,
                                 seen.green, seen.red, seen.blue);
                    end
                end
            end
        end
    end

    task automatic queue_pixel(t_pix g, t_pix r, t_pix b, int idle);
        request_t req;
        req.kind     = REQ_PIXEL;
        req.green    = g;
        req.red      = r;
        req.blue     = b;
        req.idx      = CFG_CONTRAST;
        req.data     = '0;
        req.idle_pct = idle;
        request_q.push_back(req);
    endtask

    task automatic queue_setting(t_cfg_idx idx, logic [7:0] data);
        request_t req;
        req.kind     = REQ_SETTING;
        req.green    = '0;
        req.red      = '0;
        req.blue     = '0;
        req.idx      = idx;
        req.data     = data;
        req.idle_pct = 0;
        request_q.push_back(req);
    endtask

    task automatic queue_drain();
        request_t req;
        req.kind     = REQ_DRAIN;
        req.green    = '0;
        req.red      = '0;
        req.blue     = '0;
        req.idx      = CFG_CONTRAST;
        req.data     = '0;
        req.idle_pct = 0;
        request_q.push_back(req);
    endtask

    function automatic t_pix pick_level();
        case ($urandom_range(7))
            0: return '0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            5: return 8'd255;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_percent();
        case ($urandom_range(5))
            0: return 8'($urandom_range(255));        // often out of range: saturates
            1: return 8'(PCT_MAX);
            2: return 8'(PCT_MIN);
            3: return 8'd0;
            default: return 8'($urandom_range(200) - 100);
        endcase
    endfunction

    initial begin
        int  blk;
        int  n;
        int  ch;
        int  idle;
        logic timed_out;
        t_cfg_idx min_idx;
        t_cfg_idx max_idx;

        // Reset values: every channel passes through
        queue_pixel(8'd0,   8'd0,   8'd0,   0);
        queue_pixel(8'd255, 8'd255, 8'd255, 0);
        queue_pixel(8'd128, 8'd127, 8'd1,   35);

        // Percent writes beyond range saturate; flat contrast, full brightness
        queue_setting(CFG_CONTRAST,   8'h80);
        queue_setting(CFG_BRIGHTNESS, 8'h7F);
        queue_pixel(8'd0,   8'd128, 8'd255, 0);
        queue_pixel(8'd255, 8'd1,   8'd254, 0);

        // Maximum contrast, minimum brightness; full span, min above max
        queue_setting(CFG_CONTRAST,   8'd101);
        queue_setting(CFG_BRIGHTNESS, 8'h9B);
        queue_setting(CFG_GREEN_MIN,  8'd0);
        queue_setting(CFG_GREEN_MAX,  8'd255);
        queue_setting(CFG_RED_MIN,    8'd200);
        queue_setting(CFG_RED_MAX,    8'd50);
        queue_setting(CFG_BLUE_MIN,   8'd255);
        queue_setting(CFG_BLUE_MAX,   8'd0);
        queue_pixel(8'd0,   8'd0,   8'd0,   0);
        queue_pixel(8'd255, 8'd255, 8'd255, 0);
        queue_pixel(8'd127, 8'd128, 8'd129, 35);

        // Neutral adjust; flat range, passthrough red, top-pinned blue
        queue_setting(CFG_CONTRAST,   8'd0);
        queue_setting(CFG_BRIGHTNESS, 8'd0);
        queue_setting(CFG_GREEN_MIN,  8'd10);
        queue_setting(CFG_GREEN_MAX,  8'd10);
        queue_setting(CFG_RED_MIN,    8'd0);
        queue_setting(CFG_RED_MAX,    8'd0);
        queue_setting(CFG_BLUE_MIN,   8'd255);
        queue_setting(CFG_BLUE_MAX,   8'd255);
        queue_pixel(8'd0,   8'd1,   8'd255, 0);
        queue_pixel(8'd128, 8'd128, 8'd128, 0);
        queue_pixel(8'd1,   8'd255, 8'd0,   0);

        // Exact in-range extremes and a green span of 1 to 254
        queue_setting(CFG_CONTRAST,   8'(PCT_MIN));
        queue_setting(CFG_BRIGHTNESS, 8'(PCT_MAX));
        queue_setting(CFG_GREEN_MIN,  8'd1);
        queue_setting(CFG_GREEN_MAX,  8'd254);
        queue_pixel(8'd0,   8'd200, 8'd55,  0);
        queue_setting(CFG_CONTRAST,   8'(PCT_MAX));
        queue_setting(CFG_BRIGHTNESS, 8'(PCT_MIN));
        queue_pixel(8'd255, 8'd129, 8'd127, 0);
        queue_pixel(8'd192, 8'd64,  8'd200, 0);
        queue_drain();

        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            idle = (blk < 9) ? 35 : (blk < 18) ? 67 : 0;
            queue_setting(CFG_CONTRAST,   pick_percent());
            queue_setting(CFG_BRIGHTNESS, pick_percent());
            for (ch = 0; ch < NUM_CH; ch++) begin
                min_idx = t_cfg_idx'(CFG_GREEN_MIN + 2 * ch);
                max_idx = t_cfg_idx'(CFG_GREEN_MAX + 2 * ch);
                case ($urandom_range(5))
                    0: begin
                        queue_setting(min_idx, 8'd0);
                        queue_setting(max_idx, 8'd0);
                    end
                    1: begin
                        queue_setting(min_idx, 8'd0);
                        queue_setting(max_idx, 8'd255);
                    end
                    2: begin
                        queue_setting(min_idx, 8'd255);
                        queue_setting(max_idx, 8'd0);
                    end
                    default: begin
                        queue_setting(min_idx, 8'($urandom_range(255)));
                        queue_setting(max_idx, 8'($urandom_range(255)));
                    end
                endcase
            end
            for (n = 0; n < BLOCK_ITEMS; n++) begin
                if ($urandom_range(39) == 0) queue_drain();
                if ($urandom_range(3) == 0) begin
                    queue_pixel(pick_level(), pick_level(), pick_level(), idle);
                end else begin
                    queue_pixel(t_pix'($urandom_range(255)), t_pix'($urandom_range(255)),
                                t_pix'($urandom_range(255)), idle);
                end
            end
        end

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample at the falling edge so the driver's updates have settled
        while ((request_q.size() != 0 || i_start || i_cfg_we || adjusted_q.size() != 0)
               && cycle_count < CYCLE_LIMIT) begin
            @(negedge i_clk);
        end
        timed_out = (cycle_count >= CYCLE_LIMIT);
        if (!timed_out) begin
            repeat (PIPE_DEPTH + 4) @(negedge i_clk);
        end
        if (adjusted_q.size() != 0) mismatch_count++;

        if (timed_out) begin
            $display("FAIL led_pixel_color_adjust");
        end else if (mismatch_count == 0) begin
            $display("PASS led_pixel_color_adjust");
        end else begin
            $display("FAIL led_pixel_color_adjust");
        end
        $finish;
    end

endmodule
